/* rtl/assert_macros.svh */
// Assertion macros shared by the sequencer RTL.
// No dependencies; simulation builds get the checks, synthesis gets empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property checked at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Antecedent in this cycle implies consequent in the next one.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* rtl/stpseq_pkg.sv */
// Types, widths and pin tables for the stepper full/half-step sequencer.
// No dependencies; imported by the top level.
package stpseq_pkg;

    localparam int COUNT_BITS  = 24;
    localparam int PERIOD_BITS = 20;

    localparam logic [PERIOD_BITS-1:0] STEP_PERIOD_RESET = PERIOD_BITS'(18000);

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_STOP  = 2'd2
    } op_t;

    // Pin vector bits: 0 ain1, 1 ain2, 2 bin1, 3 bin2
    localparam logic [3:0] PIN_A1 = 4'b0001;
    localparam logic [3:0] PIN_A2 = 4'b0010;
    localparam logic [3:0] PIN_B1 = 4'b0100;
    localparam logic [3:0] PIN_B2 = 4'b1000;
    localparam logic [3:0] PIN_NONE = 4'b0000;

    localparam logic [3:0] FULL_FWD_SET [4] = '{PIN_A1, PIN_B2, PIN_A2, PIN_B1};
    localparam logic [3:0] FULL_FWD_CLR [4] = '{PIN_A2, PIN_B1, PIN_A1, PIN_B2};
    localparam logic [3:0] FULL_REV_SET [4] = '{PIN_B2, PIN_A1, PIN_B1, PIN_A2};
    localparam logic [3:0] FULL_REV_CLR [4] = '{PIN_B1, PIN_A2, PIN_B2, PIN_A1};
    localparam logic [3:0] HALF_FWD_SET [8] =
        '{PIN_A1, PIN_NONE, PIN_B2, PIN_NONE, PIN_A2, PIN_NONE, PIN_B1, PIN_NONE};
    localparam logic [3:0] HALF_FWD_CLR [8] =
        '{PIN_NONE, PIN_A2, PIN_NONE, PIN_B1, PIN_NONE, PIN_A1, PIN_NONE, PIN_B2};
    localparam logic [3:0] HALF_REV_SET [8] =
        '{PIN_B2, PIN_NONE, PIN_A1, PIN_NONE, PIN_B1, PIN_NONE, PIN_A2, PIN_NONE};
    localparam logic [3:0] HALF_REV_CLR [8] =
        '{PIN_NONE, PIN_B1, PIN_NONE, PIN_A2, PIN_NONE, PIN_B2, PIN_NONE, PIN_A1};

    typedef struct packed {
        op_t                   op;
        logic                  direction;
        logic                  half_mode;
        logic [COUNT_BITS-1:0] step_count;
        logic                  continuous;
    } in_item_t;

    typedef struct packed {
        logic ain1;
        logic ain2;
        logic bin1;
        logic bin2;
        logic busy_res;
        logic done_res;
    } out_item_t;

endpackage

/* rtl/stepper_full_half_step_sequencer_top.sv */
// Stepper full/half-step sequencer: drives the four H-bridge inputs.
// The result for an input transaction is registered and valid in the next cycle.
// Throughput: one transaction per cycle while m_ready is high; the result register lets
// s_ready stay high while the held result is taken in the same cycle.
// Reset: synchronous, active-low aresetn; pins, phases, step count, timer and flags
// clear, period_reg returns to 18000.
`include "assert_macros.svh"

module stepper_full_half_step_sequencer_top
    import stpseq_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [PERIOD_BITS-1:0] cfg_wdata,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_item_t               s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_item_t              m_data
);

    logic [PERIOD_BITS-1:0] period_reg;
    logic [3:0]             pins_reg,  pins_next;
    logic [1:0]             fphase_reg, fphase_next;
    logic [2:0]             hphase_reg, hphase_next;
    logic [COUNT_BITS-1:0]  steps_reg, steps_next;
    logic [PERIOD_BITS-1:0] timer_reg, timer_next;
    logic                   busy_reg, busy_next;
    logic                   fwd_reg,  fwd_next;
    logic                   half_reg, half_next;
    logic                   cont_reg, cont_next;
    logic                   done_next;
    logic                   m_valid_reg;
    out_item_t              m_data_reg, m_data_next;

    logic                   accept;
    logic                   do_step;
    logic                   step_fwd;
    logic                   step_half;
    logic [3:0]             set_mask, clr_mask;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Move control: decides the new flags, counters and whether a step fires
    always_comb begin
        busy_next  = busy_reg;
        fwd_next   = fwd_reg;
        half_next  = half_reg;
        cont_next  = cont_reg;
        steps_next = steps_reg;
        timer_next = timer_reg;
        done_next  = 1'b0;
        do_step    = 1'b0;
        unique case (s_data.op)
            OP_START: begin
                if (s_data.step_count != '0 || s_data.continuous) begin
                    busy_next  = 1'b1;
                    fwd_next   = s_data.direction;
                    half_next  = s_data.half_mode;
                    cont_next  = s_data.continuous;
                    steps_next = s_data.continuous ? '0 : s_data.step_count - 1'b1;
                    do_step    = 1'b1;
                end
            end
            OP_STOP: begin
                busy_next  = 1'b0;
                steps_next = '0;
                timer_next = '0;
            end
            OP_TICK: begin
                if (busy_reg) begin
                    if (timer_reg > PERIOD_BITS'(1)) begin
                        timer_next = timer_reg - 1'b1;
                    end else if (cont_reg) begin
                        do_step = 1'b1;
                    end else if (steps_reg != '0) begin
                        steps_next = steps_reg - 1'b1;
                        do_step    = 1'b1;
                    end else begin
                        timer_next = '0;
                        busy_next  = 1'b0;
                        done_next  = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Step datapath: table lookup at the current phase, then advance pins and phase; a stop clears the pins
    always_comb begin
        step_fwd  = fwd_next;
        step_half = half_next;
        if (step_half) begin
            set_mask = step_fwd ? HALF_FWD_SET[hphase_reg] : HALF_REV_SET[hphase_reg];
            clr_mask = step_fwd ? HALF_FWD_CLR[hphase_reg] : HALF_REV_CLR[hphase_reg];
        end else begin
            set_mask = step_fwd ? FULL_FWD_SET[fphase_reg] : FULL_REV_SET[fphase_reg];
            clr_mask = step_fwd ? FULL_FWD_CLR[fphase_reg] : FULL_REV_CLR[fphase_reg];
        end
        pins_next   = pins_reg;
        fphase_next = fphase_reg;
        hphase_next = hphase_reg;
        if (s_data.op == OP_STOP) begin
            pins_next = '0;
        end else if (do_step) begin
            pins_next = (pins_reg & ~clr_mask) | set_mask;
            if (step_half) begin
                hphase_next = hphase_reg + 1'b1;
            end else begin
                fphase_next = fphase_reg + 1'b1;
            end
        end
    end

    always_comb begin
        m_data_next.ain1     = pins_next[0];
        m_data_next.ain2     = pins_next[1];
        m_data_next.bin1     = pins_next[2];
        m_data_next.bin2     = pins_next[3];
        m_data_next.busy_res = busy_next;
        m_data_next.done_res = done_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg  <= STEP_PERIOD_RESET;
            pins_reg    <= '0;
            fphase_reg  <= '0;
            hphase_reg  <= '0;
            steps_reg   <= '0;
            timer_reg   <= '0;
            busy_reg    <= 1'b0;
            fwd_reg     <= 1'b0;
            half_reg    <= 1'b0;
            cont_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                period_reg <= cfg_wdata;
            end
            if (accept) begin
                pins_reg   <= pins_next;
                fphase_reg <= fphase_next;
                hphase_reg <= hphase_next;
                steps_reg  <= steps_next;
                // a step reloads the interval for the mode of the move
                timer_reg  <= do_step ? (step_half ? period_reg >> 1 : period_reg)
                                      : timer_next;
                busy_reg   <= busy_next;
                fwd_reg    <= fwd_next;
                half_reg   <= half_next;
                cont_reg   <= cont_next;
            end
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

    `ASSERT_PROP(a_idle_clear, aclk, aresetn, !busy_reg |-> (timer_reg == '0 && steps_reg == '0), "idle with timer or count left")
    `ASSERT_PROP(a_cont_no_count, aclk, aresetn, (busy_reg && cont_reg) |-> steps_reg == '0, "continuous move holds a step count")
    `ASSERT_PROP(a_done_not_busy, aclk, aresetn, (m_valid_reg && m_data_reg.done_res) |-> !m_data_reg.busy_res, "done reported with busy")
    `ASSERT_NEXT(a_result_follows, aclk, aresetn, accept, m_valid_reg && m_data_reg.busy_res == busy_reg, "no result after transaction")

endmodule
